// File: sv/altitude_hold_throttle_controller_macros.svh
// ----------------------------------------------------------------------------
// altitude hold throttle controller assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_HOLD_THROTTLE_CONTROLLER_MACROS_SVH
`define ALTITUDE_HOLD_THROTTLE_CONTROLLER_MACROS_SVH

// same-cycle implication, out of reset
`define AHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aht assertion failed");

// next-cycle implication, out of reset
`define AHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aht assertion failed");

// holds in the cycle after reset is sampled
`define AHT_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("aht reset assertion failed");

`endif

// File: sv/aht_pkg.sv
// ----------------------------------------------------------------------------
// aht_pkg
// types and constants shared by the altitude hold throttle controller
// ----------------------------------------------------------------------------
`default_nettype none

package aht_pkg;

  localparam int THR_W       = 16;
  localparam int ALT_W       = 21;
  localparam int TGT_W       = 32;
  localparam int TGT_FRAC    = 9;
  localparam int ERR_W       = 24;
  localparam int PROD_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENG_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENG_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHG_MIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHG_MAX  = 3'd6;

  localparam logic signed [15:0] RST_P_GAIN  = 16'sd0;
  localparam logic signed [15:0] RST_ENG_MIN = 16'sd550;
  localparam logic signed [15:0] RST_ENG_MAX = 16'sd850;
  localparam logic signed [15:0] RST_ERR_MIN = -16'sd300;
  localparam logic [14:0]        RST_ERR_MAX = 15'd200;
  localparam logic signed [15:0] RST_CHG_MIN = -16'sd150;
  localparam logic [14:0]        RST_CHG_MAX = 15'd400;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ENGAGE  = 2'd1,
    EV_RELEASE = 2'd2
  } ind_event_t;

  typedef struct packed {
    logic signed [15:0] p_gain;
    logic signed [15:0] eng_min;
    logic signed [15:0] eng_max;
    logic signed [15:0] err_min;
    logic [14:0]        err_max;
    logic signed [15:0] chg_min;
    logic [14:0]        chg_max;
  } cfg_t;

  typedef struct packed {
    logic signed [THR_W-1:0] thr;
    logic signed [THR_W-1:0] ref_thr;
    logic signed [15:0]      err;
    logic                    ctl;
    logic                    hold;
    ind_event_t              evt;
  } s1_t;

endpackage

`default_nettype wire

// File: sv/altitude_hold_throttle_controller.sv
// an accepted input beat passes the input, front stage and result registers
// throughput: one beat per cycle unless stalled; the hold state loop closes in
// the front stage; result side stalls back up through the pipe, losing no beats
// reset (synchronous, rst_n low): hold off, switch history taken as on,
// reference throttle 0, registers to their defaults, pipe empty
// ----------------------------------------------------------------------------
// altitude_hold_throttle_controller
// altitude hold on barometric error with a q8.8 proportional correction
// ----------------------------------------------------------------------------
`default_nettype none

module altitude_hold_throttle_controller import aht_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // throttle_cmd[15:0], altitude_cm[36:16], hold_switch[37], zero[39:38]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // throttle_out[15:0], hold_active[16], indicator_event[18:17], zero[23:19]
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  cfg_t                    cfg_r;
  logic                    out_free;
  logic                    s1_valid;
  s1_t                     s1;
  logic signed [THR_W-1:0] out_thr;
  logic                    out_hold;
  ind_event_t              out_evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain  <= RST_P_GAIN;
      cfg_r.eng_min <= RST_ENG_MIN;
      cfg_r.eng_max <= RST_ENG_MAX;
      cfg_r.err_min <= RST_ERR_MIN;
      cfg_r.err_max <= RST_ERR_MAX;
      cfg_r.chg_min <= RST_CHG_MIN;
      cfg_r.chg_max <= RST_CHG_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_P_GAIN:  cfg_r.p_gain  <= cfg_wdata;
        REG_ENG_MIN: cfg_r.eng_min <= cfg_wdata;
        REG_ENG_MAX: cfg_r.eng_max <= cfg_wdata;
        REG_ERR_MIN: cfg_r.err_min <= cfg_wdata;
        REG_ERR_MAX: cfg_r.err_max <= cfg_wdata[14:0];
        REG_CHG_MIN: cfg_r.chg_min <= cfg_wdata;
        REG_CHG_MAX: cfg_r.chg_max <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  aht_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_thr    (in_tdata[15:0]),
    .in_alt    (in_tdata[36:16]),
    .in_sw     (in_tdata[37]),
    .out_free  (out_free),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  aht_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_thr    (out_thr),
    .out_hold   (out_hold),
    .out_evt    (out_evt)
  );

  assign out_tdata = {5'b0, out_evt, out_hold, out_thr};

endmodule

`default_nettype wire

// File: sv/aht_front.sv
// ----------------------------------------------------------------------------
// aht_front
// input register, hold state update and clamped altitude error
// ----------------------------------------------------------------------------
`default_nettype none

module aht_front import aht_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic signed [THR_W-1:0] in_thr,
  input  wire logic signed [ALT_W-1:0] in_alt,
  input  wire logic                    in_sw,
  input  wire logic                    out_free,
  output logic                         s1_valid,
  output s1_t                          s1
);

  logic                    in_v_r;
  logic signed [THR_W-1:0] thr_r;
  logic signed [ALT_W-1:0] alt_r;
  logic                    sw_r;

  logic                    hold_r, hold_nxt;
  logic                    prev_r, prev_nxt;
  logic signed [THR_W-1:0] ref_r, ref_nxt;
  logic [TGT_W-1:0]        tgt_r, tgt_nxt;

  logic                    s1_v_r;
  s1_t                     s1_r, s1_nxt;

  logic                    adv1;
  logic                    take;
  logic signed [THR_W:0]   diff;
  logic [TGT_W-1:0]        tgt_sum;
  logic signed [ERR_W-1:0] tgt_cm;
  logic signed [ERR_W-1:0] err_raw;
  logic signed [ERR_W-1:0] err_lo;
  logic signed [ERR_W-1:0] err_hi;
  logic signed [15:0]      err_c;
  logic signed [15:0]      eng_min;
  logic signed [15:0]      eng_max;
  logic                    engage;

  assign adv1      = !s1_v_r || out_free;
  assign take      = in_v_r && adv1;
  assign in_tready = !in_v_r || adv1;
  assign s1_valid  = s1_v_r;
  assign s1        = s1_r;

  always_comb begin
    diff    = {thr_r[THR_W-1], thr_r} - {ref_r[THR_W-1], ref_r};
    tgt_sum = tgt_r + {{(TGT_W-THR_W-1){diff[THR_W]}}, diff};
    tgt_cm  = {{(ERR_W-TGT_W+TGT_FRAC){tgt_sum[TGT_W-1]}}, tgt_sum[TGT_W-1:TGT_FRAC]};
    err_raw = tgt_cm - {{(ERR_W-ALT_W){alt_r[ALT_W-1]}}, alt_r};
    err_lo  = {{(ERR_W-16){cfg.err_min[15]}}, cfg.err_min};
    err_hi  = {{(ERR_W-15){1'b0}}, cfg.err_max};
    if (err_raw < err_lo) begin
      err_c = cfg.err_min;
    end else if (err_raw > err_hi) begin
      err_c = {1'b0, cfg.err_max};
    end else begin
      err_c = err_raw[15:0];
    end
    eng_min = cfg.eng_min;
    eng_max = cfg.eng_max;
    engage  = !hold_r && sw_r && !prev_r && (thr_r >= eng_min) && (thr_r <= eng_max);
  end

  always_comb begin
    hold_nxt       = hold_r;
    ref_nxt        = ref_r;
    tgt_nxt        = tgt_r;
    prev_nxt       = sw_r;
    s1_nxt.thr     = thr_r;
    s1_nxt.ref_thr = ref_r;
    s1_nxt.err     = err_c;
    s1_nxt.ctl     = hold_r && sw_r;
    s1_nxt.evt     = EV_NONE;
    if (hold_r) begin
      if (sw_r) begin
        tgt_nxt = tgt_sum;
      end else begin
        hold_nxt   = 1'b0;
        s1_nxt.evt = EV_RELEASE;
      end
    end else if (engage) begin
      hold_nxt   = 1'b1;
      ref_nxt    = thr_r;
      tgt_nxt    = {{(TGT_W-ALT_W-TGT_FRAC){alt_r[ALT_W-1]}}, alt_r, {TGT_FRAC{1'b0}}};
      s1_nxt.evt = EV_ENGAGE;
    end
    s1_nxt.hold = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      thr_r <= in_thr;
      alt_r <= in_alt;
      sw_r  <= in_sw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      prev_r <= 1'b1;
      ref_r  <= '0;
    end else if (take) begin
      hold_r <= hold_nxt;
      prev_r <= prev_nxt;
      ref_r  <= ref_nxt;
    end
  end

  // target has no reset, written on engage before any read
  always_ff @(posedge clk) begin
    if (take) begin
      tgt_r <= tgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/aht_back.sv
// ----------------------------------------------------------------------------
// aht_back
// gain multiply, correction clamp, saturating add and result register
// ----------------------------------------------------------------------------
`default_nettype none

module aht_back import aht_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              s1_valid,
  input  wire s1_t               s1,
  output logic                   out_free,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic signed [THR_W-1:0] out_thr,
  output logic                   out_hold,
  output ind_event_t             out_evt
);

  logic                     out_v_r;
  logic signed [THR_W-1:0]  thr_r, thr_nxt;
  logic                     hold_r;
  ind_event_t               evt_r;

  logic signed [15:0]       gain;
  logic signed [15:0]       err;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [PROD_W-1:0] lo256;
  logic signed [PROD_W-1:0] hi256;
  logic signed [15:0]       chg;
  logic signed [THR_W:0]    sum;

  assign out_free   = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_thr    = thr_r;
  assign out_hold   = hold_r;
  assign out_evt    = evt_r;

  always_comb begin
    gain     = cfg.p_gain;
    err      = s1.err;
    prod     = gain * err;
    prod_adj = prod + (prod[PROD_W-1] ? 32'sd255 : 32'sd0);
    lo256    = {{(PROD_W-24){cfg.chg_min[15]}}, cfg.chg_min, 8'b0};
    hi256    = {{(PROD_W-23){1'b0}}, cfg.chg_max, 8'b0};
    if (prod < lo256) begin
      chg = cfg.chg_min;
    end else if (prod > hi256) begin
      chg = {1'b0, cfg.chg_max};
    end else begin
      chg = prod_adj[23:8];
    end
    sum = {s1.ref_thr[THR_W-1], s1.ref_thr} + {chg[15], chg};
    if (!s1.ctl) begin
      thr_nxt = s1.thr;
    end else if (sum[THR_W] != sum[THR_W-1]) begin
      thr_nxt = sum[THR_W] ? 16'sh8000 : 16'sh7fff;
    end else begin
      thr_nxt = sum[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      thr_r  <= thr_nxt;
      hold_r <= s1.hold;
      evt_r  <= s1.evt;
    end
  end

endmodule

`default_nettype wire

// File: sv/aht_checker.sv
// ----------------------------------------------------------------------------
// aht_checker
// port level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "altitude_hold_throttle_controller_macros.svh"

module aht_checker import aht_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  `AHT_ASSERT_RST(a_rst_empty, !out_tvalid)
  `AHT_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `AHT_ASSERT_IMP(a_engage_on, out_tvalid && out_tdata[18:17] == EV_ENGAGE, out_tdata[16])
  `AHT_ASSERT_IMP(a_release_off, out_tvalid && out_tdata[18:17] == EV_RELEASE, !out_tdata[16])

endmodule

bind altitude_hold_throttle_controller aht_checker u_aht_checker (.*);

`default_nettype wire
